/* rtl/lru_pkg.sv */
// Shared constants and types for the lattice reconciliation unit.
// Used by lru_lane, lru_merge and lattice_reconciliation_unit; no dependencies.
package lru_pkg;

    localparam int MODULUS_LOG2 = 13;
    localparam int COEF_W       = 13;
    localparam int HINT_W       = 2;
    localparam int NUM_LANES    = 4;

    // signed working width: covers 8*coef+4 and 16q+8*coef with headroom
    localparam int ARITH_W = ((COEF_W + 3) > (MODULUS_LOG2 + 5) ?
                              (COEF_W + 3) : (MODULUS_LOG2 + 5)) + 2;
    localparam int GDIST_W = MODULUS_LOG2 + 1;  // distance to 2q grid, <= q
    localparam int RDIST_W = MODULUS_LOG2 + 3;  // distance to 8q grid, <= 4q
    localparam int GSUM_W  = GDIST_W + 2;
    localparam int RSUM_W  = RDIST_W + 2;

    typedef struct packed {
        logic [GDIST_W-1:0] gen_dist;
        logic [1:0]         v_near;
        logic [1:0]         v_alt;
        logic [RDIST_W-1:0] rec_dist;
    } t_lane_res;

endpackage

/* rtl/lru_lane.sv */
// One coefficient lane: rounding distances for hint generation and key recovery.
// Depends on lru_pkg.
module lru_lane (
    input  logic [lru_pkg::COEF_W-1:0] i_coef,
    input  logic                       i_rand_bit,
    input  logic [lru_pkg::HINT_W-1:0] i_hint,
    input  logic [lru_pkg::HINT_W-1:0] i_hint_last,
    input  logic                       i_is_last,
    output lru_pkg::t_lane_res         o_res
);
    import lru_pkg::*;

    logic signed [ARITH_W-1:0] x_val;
    logic signed [ARITH_W-1:0] t_gen;
    logic signed [ARITH_W-1:0] near_v;
    logic signed [ARITH_W-1:0] alt_v;
    logic signed [ARITH_W-1:0] gen_diff;
    logic signed [ARITH_W-1:0] gen_abs;
    logic        [3:0]         k_mul;
    logic signed [ARITH_W-1:0] y_val;
    logic signed [ARITH_W-1:0] t_rec;
    logic signed [ARITH_W-1:0] r_rec;
    logic signed [ARITH_W-1:0] rec_diff;
    logic signed [ARITH_W-1:0] rec_abs;

    always_comb begin
        // hint generation: x = 8v + 4*rbit, rounded onto multiples of 2q
        x_val    = (ARITH_W'(i_coef) <<< 3) + (ARITH_W'(i_rand_bit) <<< 2);
        t_gen    = x_val >>> MODULUS_LOG2;
        near_v   = (t_gen + ARITH_W'(1)) >>> 1;
        alt_v    = t_gen >>> 1;
        gen_diff = x_val - (near_v <<< (MODULUS_LOG2 + 1));
        gen_abs  = gen_diff[ARITH_W-1] ? -gen_diff : gen_diff;

        // key recovery: y = 16q + 8v - k*q, distance to nearest multiple of 8q
        k_mul    = i_is_last ? 4'(i_hint_last)
                             : (4'(i_hint) << 1) + 4'(i_hint_last);
        y_val    = (ARITH_W'(16) <<< MODULUS_LOG2) + (ARITH_W'(i_coef) <<< 3)
                 - (ARITH_W'(k_mul) <<< MODULUS_LOG2);
        t_rec    = y_val >>> (MODULUS_LOG2 + 2);
        r_rec    = (t_rec >>> 1) + ARITH_W'(t_rec[0]);
        rec_diff = (r_rec <<< (MODULUS_LOG2 + 3)) - y_val;
        rec_abs  = rec_diff[ARITH_W-1] ? -rec_diff : rec_diff;

        o_res.gen_dist = gen_abs[GDIST_W-1:0];
        o_res.v_near   = near_v[1:0];
        o_res.v_alt    = alt_v[1:0];
        o_res.rec_dist = rec_abs[RDIST_W-1:0];
    end

endmodule

/* rtl/lru_merge.sv */
// Merge stage: sums lane distances, picks the candidate vector, forms hints / key bit.
// Depends on lru_pkg.
module lru_merge (
    input  logic                       i_op,
    input  lru_pkg::t_lane_res         i_lane [lru_pkg::NUM_LANES],
    output logic [lru_pkg::HINT_W-1:0] o_hint [lru_pkg::NUM_LANES],
    output logic                       o_key_bit
);
    import lru_pkg::*;

    logic [GSUM_W-1:0] gen_sum;
    logic [RSUM_W-1:0] rec_sum;
    logic              sel;
    logic [1:0]        vt [NUM_LANES];

    always_comb begin
        gen_sum = '0;
        rec_sum = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            gen_sum = gen_sum + GSUM_W'(i_lane[i].gen_dist);
            rec_sum = rec_sum + RSUM_W'(i_lane[i].rec_dist);
        end
        sel = (gen_sum >= (GSUM_W'(2) << MODULUS_LOG2));
        for (int i = 0; i < NUM_LANES; i++) begin
            vt[i] = sel ? i_lane[i].v_alt : i_lane[i].v_near;
        end
        for (int i = 0; i < NUM_LANES - 1; i++) begin
            o_hint[i] = i_op ? '0 : HINT_W'(vt[i] - vt[NUM_LANES-1]);
        end
        // (sel + 2*v_last) mod 4
        o_hint[NUM_LANES-1] = i_op ? '0 : {vt[NUM_LANES-1][0], sel};
        o_key_bit = i_op && (rec_sum < (RSUM_W'(8) << MODULUS_LOG2));
    end

endmodule

/* rtl/lattice_reconciliation_unit.sv */
// Lattice reconciliation unit: hint generation and key-bit recovery, one group per beat.
// Top level; instantiates lru_lane (x4) and lru_merge, uses lru_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one group of four
//   coefficients with op, dither bit and received hints. Output channel
//   (o_out_valid / i_out_ready) returns one result beat per input beat:
//   four hints for op 0 (key bit zero), one key bit for op 1 (hints zero).
//   From input acceptance to o_out_valid, the four lanes are registered,
//   then the merge stage feeds the output register.
//   Throughput is one beat per cycle while the receiver is ready, set by
//   the two-stage pipeline; the lanes and merge adder tree are each combinational.
//   A stalled receiver holds the output register; the lane stage keeps
//   taking beats until it is full as well, then o_in_ready drops.
//   Synchronous active-low reset empties both stages; results in flight
//   are dropped.
module lattice_reconciliation_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_op,
    input  logic [lru_pkg::COEF_W-1:0] i_coef_a,
    input  logic [lru_pkg::COEF_W-1:0] i_coef_b,
    input  logic [lru_pkg::COEF_W-1:0] i_coef_c,
    input  logic [lru_pkg::COEF_W-1:0] i_coef_d,
    input  logic                       i_rand_bit,
    input  logic [lru_pkg::HINT_W-1:0] i_hint_in_a,
    input  logic [lru_pkg::HINT_W-1:0] i_hint_in_b,
    input  logic [lru_pkg::HINT_W-1:0] i_hint_in_c,
    input  logic [lru_pkg::HINT_W-1:0] i_hint_in_d,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [lru_pkg::HINT_W-1:0] o_hint_out_a,
    output logic [lru_pkg::HINT_W-1:0] o_hint_out_b,
    output logic [lru_pkg::HINT_W-1:0] o_hint_out_c,
    output logic [lru_pkg::HINT_W-1:0] o_hint_out_d,
    output logic                       o_key_bit
);
    import lru_pkg::*;

    logic [COEF_W-1:0] coef    [NUM_LANES];
    logic [HINT_W-1:0] hint_in [NUM_LANES];
    t_lane_res         lane_res [NUM_LANES];

    t_lane_res         r_lane  [NUM_LANES];
    logic              r_s1_op;
    logic              r_s1_valid;
    logic              n_s1_valid;

    logic [HINT_W-1:0] mrg_hint [NUM_LANES];
    logic              mrg_key;
    logic [HINT_W-1:0] r_hint  [NUM_LANES];
    logic              r_key;
    logic              r_out_valid;
    logic              n_out_valid;

    logic              s2_ready;
    logic              s1_ready;
    logic              s1_load;
    logic              s2_load;

    assign coef[0]    = i_coef_a;
    assign coef[1]    = i_coef_b;
    assign coef[2]    = i_coef_c;
    assign coef[3]    = i_coef_d;
    assign hint_in[0] = i_hint_in_a;
    assign hint_in[1] = i_hint_in_b;
    assign hint_in[2] = i_hint_in_c;
    assign hint_in[3] = i_hint_in_d;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        lru_lane u_lane (
            .i_coef      (coef[g]),
            .i_rand_bit  (i_rand_bit),
            .i_hint      (hint_in[g]),
            .i_hint_last (hint_in[NUM_LANES-1]),
            .i_is_last   (1'(g == NUM_LANES - 1)),
            .o_res       (lane_res[g])
        );
    end

    lru_merge u_merge (
        .i_op      (r_s1_op),
        .i_lane    (r_lane),
        .o_hint    (mrg_hint),
        .o_key_bit (mrg_key)
    );

    // pipeline handshake: each stage advances when the next one has room
    assign s2_ready   = !r_out_valid || i_out_ready;
    assign s1_ready   = !r_s1_valid || s2_ready;
    assign o_in_ready = s1_ready;
    assign s1_load    = i_in_valid && s1_ready;
    assign s2_load    = r_s1_valid && s2_ready;

    always_comb begin
        n_s1_valid  = s1_ready ? i_in_valid : r_s1_valid;
        n_out_valid = s2_ready ? r_s1_valid : r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_lane  <= lane_res;
            r_s1_op <= i_op;
        end
        if (s2_load) begin
            r_hint <= mrg_hint;
            r_key  <= mrg_key;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_hint_out_a = r_hint[0];
    assign o_hint_out_b = r_hint[1];
    assign o_hint_out_c = r_hint[2];
    assign o_hint_out_d = r_hint[3];
    assign o_key_bit    = r_key;

endmodule
